@@ rtl/drm_pkg.sv @@
package drm_pkg;

  // Fixed-point scales: voltages at 1/2048 V, gains at Q1.14
  localparam int unsigned UNIT_ONE  = 16384;
  localparam int unsigned VOLT10    = 20480;
  localparam int unsigned KNEE_GAP  = 2;
  localparam int unsigned SLOPE_MIN = 1638;
  localparam int unsigned SLOPE_MAX = 16384;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_BIAS_KNOB   = 3'd0,
    CFG_BIAS_ATTEN  = 3'd1,
    CFG_KNEE_KNOB   = 3'd2,
    CFG_KNEE_ATTEN  = 3'd3,
    CFG_SLOPE_KNOB  = 3'd4,
    CFG_SLOPE_ATTEN = 3'd5,
    CFG_WET_MIX     = 3'd6
  } cfg_idx_t;

  // Segment of the diode curve
  typedef enum logic [1:0] {
    REGION_ZERO,
    REGION_QUAD,
    REGION_LIN
  } region_t;

endpackage

@@ rtl/diode_ring_modulator_core.sv @@
// Diode ring modulator core.
// Input channel: in_valid / in_stall with signal_in, carrier_in and the bias,
// knee and slope control voltages, one sample per item. Output channel:
// out_valid / out_stall with mix_out, one result item per input item.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high; the user must write registers only while the block is idle, which the block does not enforce.
// One item is taken in every cycle while the receiver does not stall. The
// pipeline has 23 stages, whose longest part is the 15-stage restoring
// divider by the knee width, one quotient bit a stage.
// At reset all valid bits clear and the registers take their default values.
// When the receiver stalls a finished item, every stage holds and in_stall
// rises in the same cycle, so nothing is lost or repeated.
module diode_ring_modulator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] signal_in,
  input  logic signed [15:0] carrier_in,
  input  logic signed [15:0] bias_cv,
  input  logic signed [15:0] knee_cv,
  input  logic signed [15:0] slope_cv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] mix_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NST   = 23;
  localparam int NDIV  = 15;

  // Configuration registers
  logic [14:0]        bias_knob, knee_knob, slope_knob, wet_mix;
  logic signed [15:0] bias_atten, knee_atten, slope_atten;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_knob   <= 15'd0;
      bias_atten  <= 16'sd0;
      knee_knob   <= 15'd1024;
      knee_atten  <= 16'sd0;
      slope_knob  <= 15'd16384;
      slope_atten <= 16'sd0;
      wet_mix     <= 15'd8192;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        drm_pkg::CFG_BIAS_KNOB:   bias_knob   <= cfg_data[14:0];
        drm_pkg::CFG_BIAS_ATTEN:  bias_atten  <= $signed(cfg_data);
        drm_pkg::CFG_KNEE_KNOB:   knee_knob   <= cfg_data[14:0];
        drm_pkg::CFG_KNEE_ATTEN:  knee_atten  <= $signed(cfg_data);
        drm_pkg::CFG_SLOPE_KNOB:  slope_knob  <= cfg_data[14:0];
        drm_pkg::CFG_SLOPE_ATTEN: slope_atten <= $signed(cfg_data);
        drm_pkg::CFG_WET_MIX:     wet_mix     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the output item is stalled
  logic           en;
  logic [NST:1]   vld;

  assign en        = !(vld[NST] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], in_valid};
    end
  end

  // Stage 1: control voltage products, A and B at 1/4096 V
  logic signed [31:0] pb1, pk1, ps1;
  logic signed [17:0] a21, b21, car_x, sig_x;
  logic signed [15:0] sig1;

  assign car_x = 18'(carrier_in);
  assign sig_x = 18'(signal_in);

  always_ff @(posedge clk) begin
    if (en) begin
      pb1  <= 32'(bias_cv * bias_atten);
      pk1  <= 32'(knee_cv * knee_atten);
      ps1  <= 32'(slope_cv * slope_atten);
      a21  <= (car_x <<< 1) + sig_x;
      b21  <= (car_x <<< 1) - sig_x;
      sig1 <= signal_in;
    end
  end

  // Stage 2: clamp bias and knee, start slope division by ten volts
  logic signed [17:0] rb, rk;
  logic signed [18:0] bsum, ksum, kmin, bias_lo;
  logic [14:0]        bias_c, knee_c;
  logic signed [19:0] us;
  logic [19:0]        u_c;
  logic [14:0]        bias2, knee2;
  logic [19:0]        u2;
  logic [37:0]        up2;
  logic signed [17:0] a22, b22;
  logic signed [15:0] sig2;

  always_comb begin
    rb   = 18'((pb1 + 32'sd8192) >>> 14);
    rk   = 18'((pk1 + 32'sd8192) >>> 14);
    bsum = $signed(19'(bias_knob)) + 19'(rb);
    ksum = $signed(19'(knee_knob)) + 19'(rk);
    if (bsum < 19'sd0) begin
      bias_c = 15'd0;
    end else if (bsum > 19'sd20480) begin
      bias_c = 15'(drm_pkg::VOLT10);
    end else begin
      bias_c = bsum[14:0];
    end
    bias_lo = $signed(19'(bias_c)) + 19'sd2;
    kmin    = (ksum > 19'sd20480) ? 19'sd20480 : ksum;
    knee_c  = (kmin < bias_lo) ? bias_lo[14:0] : kmin[14:0];
    // floor((p + 10240) / 20480) as floor(floor((p + 10240) / 4096) / 5), offset positive
    us  = 20'((ps1 + 32'sd10240) >>> 12);
    u_c = $unsigned(us) + 20'd655360;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bias2 <= bias_c;
      knee2 <= knee_c;
      u2    <= u_c;
      up2   <= 38'(u_c * 18'd209715);
      a22   <= a21;
      b22   <= b21;
      sig2  <= sig1;
    end
  end

  // Stage 3: finish slope quotient and clamp, form knee width
  logic [17:0]        qe;
  logic [20:0]        rem5;
  logic [17:0]        qs;
  logic signed [20:0] sv;
  logic [14:0]        h_c;
  logic [14:0]        h3;
  logic [15:0]        bb3, kk3, w3;
  logic signed [17:0] a23, b23;
  logic signed [15:0] sig3;

  always_comb begin
    qe   = up2[37:20];
    rem5 = 21'(u2) - 21'(qe * 21'd5);
    qs   = (rem5 >= 21'd5) ? qe + 18'd1 : qe;
    sv   = $signed(21'(slope_knob)) + $signed(21'(qs)) - 21'sd131072;
    if (sv < 21'sd1638) begin
      h_c = 15'(drm_pkg::SLOPE_MIN);
    end else if (sv > 21'sd16384) begin
      h_c = 15'(drm_pkg::SLOPE_MAX);
    end else begin
      h_c = sv[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h3   <= h_c;
      bb3  <= {bias2, 1'b0};
      kk3  <= {knee2, 1'b0};
      w3   <= {knee2, 1'b0} - {bias2, 1'b0};
      a23  <= a22;
      b23  <= b22;
      sig3 <= sig2;
    end
  end

  // Stage 4: pick the curve segment for +A, -A, +B, -B
  logic signed [17:0]  xl [4];
  logic signed [17:0]  bbs, kks;
  drm_pkg::region_t    reg_c [4];
  drm_pkg::region_t    reg4 [4];
  logic [15:0]         d4 [4];
  logic [16:0]         xk4 [4];
  logic [14:0]         h4;
  logic [15:0]         w4;
  logic signed [15:0]  sig4;

  always_comb begin
    xl[0] = a23;
    xl[1] = -a23;
    xl[2] = b23;
    xl[3] = -b23;
    bbs   = $signed({2'b00, bb3});
    kks   = $signed({2'b00, kk3});
    for (int l = 0; l < 4; l++) begin
      if (xl[l] <= bbs) begin
        reg_c[l] = drm_pkg::REGION_ZERO;
      end else if (xl[l] <= kks) begin
        reg_c[l] = drm_pkg::REGION_QUAD;
      end else begin
        reg_c[l] = drm_pkg::REGION_LIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        reg4[l] <= reg_c[l];
        d4[l]   <= 16'(xl[l] - bbs);
        xk4[l]  <= 17'(xl[l] - kks);
      end
      h4   <= h3;
      w4   <= w3;
      sig4 <= sig3;
    end
  end

  // Stage 5: square and slope products
  drm_pkg::region_t    reg5 [4];
  logic [31:0]         dd5 [4];
  logic [31:0]         hxk5 [4];
  logic [30:0]         hw5;
  logic [14:0]         h5;
  logic [15:0]         w5;
  logic signed [15:0]  sig5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        reg5[l] <= reg4[l];
        dd5[l]  <= 32'(d4[l] * d4[l]);
        hxk5[l] <= 32'(h4 * xk4[l]);
      end
      hw5  <= 31'(h4 * w4);
      h5   <= h4;
      w5   <= w4;
      sig5 <= sig4;
    end
  end

  // Stage 6: rounded quadratic numerator and linear segment value
  logic [45:0]         np_c [4];
  logic [33:0]         ln_c [4];

  // Divider pipeline, entry 0 is loaded here
  logic [31:0]         drem [0:NDIV][4];
  logic [14:0]         dquo [0:NDIV][4];
  logic [17:0]         dlin [0:NDIV][4];
  drm_pkg::region_t    dreg [0:NDIV][4];
  logic [15:0]         dw   [0:NDIV];
  logic signed [15:0]  dsig [0:NDIV];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      np_c[l] = 46'(h5 * dd5[l]) + 46'({w5, 14'b0});
      ln_c[l] = 34'({hxk5[l], 1'b0}) + 34'(hw5) + 34'd16384;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        drem[0][l] <= 32'(np_c[l][45:15]);
        dquo[0][l] <= 15'd0;
        dlin[0][l] <= ln_c[l][32:15];
        dreg[0][l] <= reg5[l];
      end
      dw[0]   <= w5;
      dsig[0] <= sig5;
    end
  end

  // Divider steps: one quotient bit per stage, most significant first
  logic [31:0]         dsub [1:NDIV];
  logic                dge  [1:NDIV][4];

  always_comb begin
    for (int s = 1; s <= NDIV; s++) begin
      dsub[s] = 32'(dw[s-1]) << (NDIV - s);
      for (int l = 0; l < 4; l++) begin
        dge[s][l] = (drem[s-1][l] >= dsub[s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= NDIV; s++) begin
        for (int l = 0; l < 4; l++) begin
          drem[s][l] <= dge[s][l] ? drem[s-1][l] - dsub[s] : drem[s-1][l];
          dquo[s][l] <= dquo[s-1][l] | (dge[s][l] ? 15'(1) << (NDIV - s) : 15'd0);
          dlin[s][l] <= dlin[s-1][l];
          dreg[s][l] <= dreg[s-1][l];
        end
        dw[s]   <= dw[s-1];
        dsig[s] <= dsig[s-1];
      end
    end
  end

  // Stage 22: select diode outputs and form the wet sum
  logic signed [19:0]  dv [4];
  logic signed [19:0]  res22;
  logic signed [15:0]  sig22;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      case (dreg[NDIV][l])
        drm_pkg::REGION_QUAD: dv[l] = $signed(20'(dquo[NDIV][l]));
        drm_pkg::REGION_LIN:  dv[l] = $signed(20'(dlin[NDIV][l]));
        default:              dv[l] = 20'sd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res22 <= dv[0] + dv[1] - dv[2] - dv[3];
      sig22 <= dsig[NDIV];
    end
  end

  // Stage 23: blend with the dry signal and saturate
  logic [14:0]         m_c;
  logic signed [34:0]  acc;
  logic signed [19:0]  mix_c;

  always_comb begin
    m_c   = (wet_mix > 15'd16384) ? 15'd16384 : wet_mix;
    acc   = 35'($signed({1'b0, m_c}) * res22)
          + 35'($signed(16'(16'd16384 - 16'(m_c))) * $signed({sig22, 1'b0}))
          + 35'sd16384;
    mix_c = 20'(acc >>> 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (mix_c > 20'sd32767) begin
        mix_out <= 16'sd32767;
      end else if (mix_c < -20'sd32768) begin
        mix_out <= -16'sd32768;
      end else begin
        mix_out <= mix_c[15:0];
      end
    end
  end

  // Checks on pipeline control and parameter derivation
  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_knee_gap: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (16'(knee2) >= 16'(bias2) + 16'd2))
    else $error("knee below bias plus gap");

  a_slope_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (h3 >= 15'(drm_pkg::SLOPE_MIN) && h3 <= 15'(drm_pkg::SLOPE_MAX)))
    else $error("slope outside its clamp");

endmodule

@@ sim/testbench.sv @@
module testbench;

  localparam int LATENCY   = 23;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 500;

  // Signed copies of the package scales for the predictor
  localparam longint L_UNIT_ONE  = longint'(drm_pkg::UNIT_ONE);
  localparam longint L_VOLT10    = longint'(drm_pkg::VOLT10);
  localparam longint L_KNEE_GAP  = longint'(drm_pkg::KNEE_GAP);
  localparam longint L_SLOPE_MIN = longint'(drm_pkg::SLOPE_MIN);
  localparam longint L_SLOPE_MAX = longint'(drm_pkg::SLOPE_MAX);

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] signal_in;
  logic signed [15:0] carrier_in;
  logic signed [15:0] bias_cv;
  logic signed [15:0] knee_cv;
  logic signed [15:0] slope_cv;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] mix_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  diode_ring_modulator_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .signal_in(signal_in), .carrier_in(carrier_in),
    .bias_cv(bias_cv), .knee_cv(knee_cv), .slope_cv(slope_cv),
    .out_valid(out_valid), .out_stall(out_stall), .mix_out(mix_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Sample fields of one input item
  typedef struct packed {
    logic signed [15:0] sig;
    logic signed [15:0] car;
    logic signed [15:0] bcv;
    logic signed [15:0] kcv;
    logic signed [15:0] scv;
  } sample_t;

  // Directed row: item plus typed-in result where obvious
  typedef struct {
    sample_t            smp;
    bit                 known;
    logic signed [15:0] mix;
  } row_t;

  // Shadow copy of the knob registers
  logic [14:0]        bias_knob_q, knee_knob_q, slope_knob_q, wet_mix_q;
  logic signed [15:0] bias_atten_q, knee_atten_q, slope_atten_q;

  logic signed [15:0] mix_queue[$];
  int   fail_count;
  int   cycle_count;
  int   items_sent;
  int   results_seen;
  bit   idle_free;
  bit   sending;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Floor division and round-half-up
  function automatic longint fdiv(longint x, longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic longint rnd(longint x, longint d);
    return fdiv(x + d / 2, d);
  endfunction

  function automatic longint diode_curve(longint x, longint b, longint k, longint h);
    longint w, d;
    w = k - b;
    if (x <= b) return 0;
    if (x <= k) begin
      d = x - b;
      return rnd(h * d * d, 2 * w * L_UNIT_ONE);
    end
    return rnd(2 * h * (x - k) + h * w, 2 * L_UNIT_ONE);
  endfunction

  function automatic logic signed [15:0] ring_mix(sample_t s);
    longint bias, knee, h, m, a2, b2, res, mix;
    bias = longint'(bias_knob_q) + rnd(longint'(s.bcv) * bias_atten_q, L_UNIT_ONE);
    if (bias < 0) bias = 0;
    if (bias > L_VOLT10) bias = L_VOLT10;
    knee = longint'(knee_knob_q) + rnd(longint'(s.kcv) * knee_atten_q, L_UNIT_ONE);
    if (knee > L_VOLT10) knee = L_VOLT10;
    if (knee < bias + L_KNEE_GAP) knee = bias + L_KNEE_GAP;
    h = longint'(slope_knob_q) + rnd(longint'(s.scv) * slope_atten_q, 20480);
    if (h > L_SLOPE_MAX) h = L_SLOPE_MAX;
    if (h < L_SLOPE_MIN) h = L_SLOPE_MIN;
    a2 = 2 * longint'(s.car) + s.sig;
    b2 = 2 * longint'(s.car) - s.sig;
    res = diode_curve(a2, 2 * bias, 2 * knee, h) + diode_curve(-a2, 2 * bias, 2 * knee, h)
        - diode_curve(b2, 2 * bias, 2 * knee, h) - diode_curve(-b2, 2 * bias, 2 * knee, h);
    m = longint'(wet_mix_q);
    if (m > L_UNIT_ONE) m = L_UNIT_ONE;
    mix = rnd(m * res + (L_UNIT_ONE - m) * 2 * longint'(s.sig), 2 * L_UNIT_ONE);
    if (mix > 32767) mix = 32767;
    if (mix < -32768) mix = -32768;
    return mix[15:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch @%0d: %s", cycle_count, what);
    fail_count++;
  endtask

  function automatic bit idle_roll();
    return !idle_free && ($urandom_range(99) < 36);
  endfunction

  // Check results at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (mix_queue.size() == 0)
        report_mismatch($sformatf("unexpected mix_out %0d", mix_out));
      else begin
        if (mix_out !== mix_queue[0])
          report_mismatch($sformatf("mix_out %0d, want %0d", mix_out, mix_queue[0]));
        void'(mix_queue.pop_front());
      end
    end
  end

  // Random receiver stall on the falling edge
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= idle_roll();
  end

  // Abort on runaway
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("diode_ring_modulator_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(drm_pkg::cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      drm_pkg::CFG_BIAS_KNOB:   bias_knob_q   = value[14:0];
      drm_pkg::CFG_BIAS_ATTEN:  bias_atten_q  = value;
      drm_pkg::CFG_KNEE_KNOB:   knee_knob_q   = value[14:0];
      drm_pkg::CFG_KNEE_ATTEN:  knee_atten_q  = value;
      drm_pkg::CFG_SLOPE_KNOB:  slope_knob_q  = value[14:0];
      drm_pkg::CFG_SLOPE_ATTEN: slope_atten_q = value;
      drm_pkg::CFG_WET_MIX:     wet_mix_q     = value[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one item; expectation pushed on acceptance
  task automatic send_item(sample_t s, bit known, logic signed [15:0] mix);
    logic signed [15:0] want;
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    signal_in  <= s.sig;
    carrier_in <= s.car;
    bias_cv    <= s.bcv;
    knee_cv    <= s.kcv;
    slope_cv   <= s.scv;
    want = ring_mix(s);
    if (known && want !== mix)
      report_mismatch($sformatf("predictor %0d, table %0d", want, mix));
    do @(posedge clk); while (in_stall);
    mix_queue.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (mix_queue.size() != 0) @(posedge clk);
    while (n < LATENCY + 4) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic sample_t rand_sample(bit tame);
    sample_t s;
    s.sig = 16'($urandom);
    s.car = 16'($urandom);
    s.bcv = 16'($urandom);
    s.kcv = 16'($urandom);
    s.scv = 16'($urandom);
    // Keep most samples in the musical range so all curve segments appear
    if (tame) begin
      s.sig = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
      s.car = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
      s.bcv = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      s.kcv = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
    end
    return s;
  endfunction

  task automatic random_regs();
    write_reg(drm_pkg::CFG_BIAS_KNOB,   16'($urandom_range(0, 4000)));
    write_reg(drm_pkg::CFG_BIAS_ATTEN,  16'($signed($urandom_range(0, 32768)) - 16384));
    write_reg(drm_pkg::CFG_KNEE_KNOB,   16'($urandom_range(0, 20480)));
    write_reg(drm_pkg::CFG_KNEE_ATTEN,  16'($signed($urandom_range(0, 32768)) - 16384));
    write_reg(drm_pkg::CFG_SLOPE_KNOB,  16'($urandom_range(1638, 16384)));
    write_reg(drm_pkg::CFG_SLOPE_ATTEN, 16'($signed($urandom_range(0, 32768)) - 16384));
    write_reg(drm_pkg::CFG_WET_MIX,     16'($urandom_range(0, 16384)));
  endtask

  initial begin
    row_t    rows[$];
    sample_t s;
    int      k;
    rst = 1'b1;
    in_valid = 1'b0; cfg_valid = 1'b0;
    cfg_index = drm_pkg::CFG_BIAS_KNOB; cfg_data = '0;
    signal_in = '0; carrier_in = '0; bias_cv = '0; knee_cv = '0; slope_cv = '0;
    fail_count = 0; cycle_count = 0; items_sent = 0; results_seen = 0;
    idle_free = 1'b0;
    bias_knob_q = 15'd0; bias_atten_q = 16'sd0; knee_knob_q = 15'd1024;
    knee_atten_q = 16'sd0; slope_knob_q = 15'd16384; slope_atten_q = 16'sd0;
    wet_mix_q = 15'd8192;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset defaults, silence and half-dry extremes
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, 16'sd0});
    rows.push_back('{'{16'sd2048, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0, 16'sd0});
    rows.push_back('{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0, 16'sd0});
    rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0, 16'sd0});
    rows.push_back('{'{16'sd4096, 16'sd4096, 16'sd0, 16'sd0, 16'sd0}, 0, 16'sd0});
    rows.push_back('{'{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 0, 16'sd0});
    rows.push_back('{'{16'sd500, 16'sd100, 16'sd0, 16'sd0, 16'sd0}, 0, 16'sd0});
    foreach (rows[i]) send_item(rows[i].smp, rows[i].known, rows[i].mix);
    drain();

    // Fully wet, hard bias at the top: knee bounds cross
    write_reg(drm_pkg::CFG_WET_MIX, 16'd16384);
    write_reg(drm_pkg::CFG_BIAS_KNOB, 16'd20480);
    write_reg(drm_pkg::CFG_BIAS_ATTEN, 16'h4000);
    write_reg(drm_pkg::CFG_KNEE_ATTEN, 16'hC000);
    write_reg(drm_pkg::CFG_SLOPE_ATTEN, 16'h4000);
    write_reg(drm_pkg::CFG_SLOPE_KNOB, 16'd1638);
    rows.delete();
    rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 0, 16'sd0});
    rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 0, 16'sd0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, 16'sd0});
    rows.push_back('{'{16'sd1000, -16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 0, 16'sd0});
    foreach (rows[i]) send_item(rows[i].smp, rows[i].known, rows[i].mix);
    drain();

    // Out-of-range registers: wet above one, knobs beyond their span
    write_reg(drm_pkg::CFG_WET_MIX, 16'h7FFF);
    write_reg(drm_pkg::CFG_BIAS_KNOB, 16'd0);
    write_reg(drm_pkg::CFG_BIAS_ATTEN, 16'h8000);
    write_reg(drm_pkg::CFG_KNEE_KNOB, 16'h7FFF);
    write_reg(drm_pkg::CFG_KNEE_ATTEN, 16'h7FFF);
    write_reg(drm_pkg::CFG_SLOPE_KNOB, 16'h7FFF);
    write_reg(drm_pkg::CFG_SLOPE_ATTEN, 16'h8000);
    rows.delete();
    rows.push_back('{'{16'sd8000, 16'sd3000, -16'sd32768, 16'sd32767, 16'sd32767}, 0, 16'sd0});
    rows.push_back('{'{-16'sd8000, 16'sd3000, 16'sd32767, -16'sd32768, -16'sd32768}, 0, 16'sd0});
    rows.push_back('{'{16'sd300, -16'sd200, 16'sd5, -16'sd5, 16'sd0}, 0, 16'sd0});
    foreach (rows[i]) send_item(rows[i].smp, rows[i].known, rows[i].mix);
    drain();

    // Dry-only, dry output is the saturated signal itself
    write_reg(drm_pkg::CFG_WET_MIX, 16'd0);
    rows.delete();
    rows.push_back('{'{16'sd32767, 16'sd1234, 16'sd0, 16'sd0, 16'sd0}, 1, 16'sd32767});
    rows.push_back('{'{-16'sd32768, 16'sd1234, 16'sd0, 16'sd0, 16'sd0}, 1, -16'sd32768});
    rows.push_back('{'{16'sd100, -16'sd99, 16'sd0, 16'sd0, 16'sd0}, 1, 16'sd100});
    foreach (rows[i]) send_item(rows[i].smp, rows[i].known, rows[i].mix);
    drain();

    // Random phases, each with its own register setting
    k = 0;
    while (k < N_RANDOM) begin
      random_regs();
      idle_free = ((k / 50) % 4 == 2);
      for (int j = 0; j < 50; j++) begin
        s = rand_sample($urandom_range(99) < 75);
        send_item(s, 0, 16'sd0);
        k++;
      end
      drain();
    end

    $display("covered %0d items, %0d results over directed extremes and %0d random settings",
             items_sent, results_seen, N_RANDOM / 50);
    if (fail_count == 0)
      $display("diode_ring_modulator_core regression: pass");
    else
      $display("diode_ring_modulator_core regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/drm_pkg.sv
rtl/diode_ring_modulator_core.sv
sim/testbench.sv
